// File: hdl/dpfa_pkg.sv
// shared types and constants of the detector packet frame assembler
`default_nettype none
package dpfa_pkg;

  // frame geometry
  localparam int unsigned PACKETS_PER_FRAME = 128;
  localparam int unsigned BYTES_PER_PACKET  = 8192;

  localparam logic [7:0]  PKT_LIMIT   = 8'(PACKETS_PER_FRAME);
  localparam logic [7:0]  PKT_FINAL   = 8'(PACKETS_PER_FRAME - 1);
  localparam logic [19:0] PKT_BYTES   = 20'(BYTES_PER_PACKET);
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULE_NUMBER     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_MIN_PULSE = 1'd1;
  localparam logic [63:0] FORWARD_MIN_PULSE_RESET = 64'd10;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PLACE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // back-end sequencer over the results of one request
  typedef enum logic [1:0] {
    BS_FIRST = 2'd0,
    BS_MAIN  = 2'd1,
    BS_POST  = 2'd2
  } back_state_t;

  // one classified request: optional close, placement or error, optional close
  typedef struct packed {
    logic        pre_close;
    logic [63:0] pre_pulse;
    logic [63:0] pre_frame;
    logic [31:0] pre_debug;
    logic [7:0]  pre_count;
    logic        pre_forward;
    kind_t       main_kind;
    logic [19:0] main_offset;
    logic [63:0] main_pulse;
    logic [63:0] main_frame;
    logic [31:0] main_debug;
    logic [7:0]  main_count;
    logic        post_close;
    logic        post_forward;
  } queue_entry_t;

  // one result as held in the output register
  typedef struct packed {
    kind_t       kind;
    logic [19:0] write_offset;
    logic [63:0] pulse_tag;
    logic [63:0] frame_seq;
    logic [31:0] debug_info;
    logic [31:0] module_tag;
    logic [7:0]  packets_received;
    logic        forward;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/dpfa_if.sv
// valid/ready channel interfaces for packet headers and results
`default_nettype none
interface dpfa_header_if;
  logic        valid;
  logic        ready;
  logic [63:0] bunch_id;
  logic [7:0]  packet_number;
  logic [63:0] frame_number;
  logic [31:0] debug_word;

  modport source (output valid, output bunch_id, output packet_number,
                  output frame_number, output debug_word, input ready);
  modport sink   (input valid, input bunch_id, input packet_number,
                  input frame_number, input debug_word, output ready);
endinterface

interface dpfa_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [19:0] write_offset;
  logic [63:0] pulse_tag;
  logic [63:0] frame_seq;
  logic [31:0] debug_info;
  logic [31:0] module_tag;
  logic [7:0]  packets_received;
  logic        forward;
  logic        last;

  modport source (output valid, output kind, output write_offset, output pulse_tag,
                  output frame_seq, output debug_info, output module_tag,
                  output packets_received, output forward, output last,
                  input ready);
  modport sink   (input valid, input kind, input write_offset, input pulse_tag,
                  input frame_seq, input debug_info, input module_tag,
                  input packets_received, input forward, input last,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/dpfa_front.sv
// front end: accepts packet headers, tracks the open frame, classifies requests
`default_nettype none
module dpfa_front
  import dpfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  dpfa_header_if.sink       header,
  input  wire logic [63:0]  forward_min_pulse,
  input  wire logic         full,
  output logic              push,
  output queue_entry_t      entry
);

  logic [63:0] current_bunch, current_bunch_next;
  logic        frame_open, frame_open_next;
  logic [63:0] open_pulse, open_pulse_next;
  logic [63:0] open_frame_number, open_frame_number_next;
  logic [31:0] open_debug_word, open_debug_word_next;
  logic [7:0]  packet_count, packet_count_next;

  logic bunch_change;
  logic still_open;
  logic bad_index;

  // request accepted whenever the queue has room
  assign header.ready = !full;
  assign push         = header.valid && !full;

  // classify the header and work out the frame state after it
  always_comb begin
    bunch_change = header.bunch_id != current_bunch;
    still_open   = frame_open && !bunch_change;
    bad_index    = header.packet_number >= PKT_LIMIT;

    current_bunch_next     = header.bunch_id;
    frame_open_next        = still_open;
    open_pulse_next        = open_pulse;
    open_frame_number_next = open_frame_number;
    open_debug_word_next   = open_debug_word;
    packet_count_next      = packet_count;

    entry.pre_close   = bunch_change && frame_open;
    entry.pre_pulse   = open_pulse;
    entry.pre_frame   = open_frame_number;
    entry.pre_debug   = open_debug_word;
    entry.pre_count   = packet_count;
    entry.pre_forward = open_pulse > forward_min_pulse;

    if (bad_index) begin
      entry.main_kind   = KIND_ERROR;
      entry.main_offset = '0;
      entry.main_pulse  = header.bunch_id;
      entry.main_frame  = header.frame_number;
      entry.main_debug  = header.debug_word;
      entry.main_count  = packet_count;
      entry.post_close  = 1'b0;
    end else begin
      // open a new frame when none survives the bunch check
      if (!still_open) begin
        open_pulse_next        = header.bunch_id;
        open_frame_number_next = header.frame_number;
        open_debug_word_next   = header.debug_word;
        packet_count_next      = '0;
      end
      if (packet_count_next != COUNT_MAX) begin
        packet_count_next = packet_count_next + 8'd1;
      end
      entry.main_kind   = KIND_PLACE;
      entry.main_offset = PKT_BYTES * 20'(header.packet_number);
      entry.main_pulse  = open_pulse_next;
      entry.main_frame  = open_frame_number_next;
      entry.main_debug  = open_debug_word_next;
      entry.main_count  = packet_count_next;
      entry.post_close  = header.packet_number == PKT_FINAL;
      frame_open_next   = !entry.post_close;
    end
    entry.post_forward = entry.main_pulse > forward_min_pulse;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_bunch     <= '0;
      frame_open        <= 1'b0;
      open_pulse        <= '0;
      open_frame_number <= '0;
      open_debug_word   <= '0;
      packet_count      <= '0;
    end else if (push) begin
      current_bunch     <= current_bunch_next;
      frame_open        <= frame_open_next;
      open_pulse        <= open_pulse_next;
      open_frame_number <= open_frame_number_next;
      open_debug_word   <= open_debug_word_next;
      packet_count      <= packet_count_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dpfa_queue.sv
// short request queue between the front and back ends
`default_nettype none
module dpfa_queue
  import dpfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire queue_entry_t push_entry,
  input  wire logic         pop,
  output queue_entry_t      head,
  output logic              empty,
  output logic              full
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  queue_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == CNT_FULL;
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("request popped from an empty queue");
`endif

endmodule
`default_nettype wire

// File: hdl/dpfa_back.sv
// back end: expands each request into its results behind an output register
`default_nettype none
module dpfa_back
  import dpfa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire queue_entry_t head,
  input  wire logic         empty,
  input  wire logic [31:0]  module_number,
  output logic              pop,
  dpfa_result_if.source     result
);

  back_state_t state, state_next;
  result_t     out_reg, out_next;
  logic        out_valid;
  logic        load;

  // output register takes the next result of a queued request when empty or being drained
  assign load = !empty && (!out_valid || result.ready);

  // next state
  always_comb begin
    state_next = state;
    if (load) begin
      unique case (state)
        BS_FIRST: begin
          if (head.pre_close) begin
            state_next = BS_MAIN;
          end else if (head.post_close) begin
            state_next = BS_POST;
          end else begin
            state_next = BS_FIRST;
          end
        end
        BS_MAIN: state_next = head.post_close ? BS_POST : BS_FIRST;
        BS_POST: state_next = BS_FIRST;
        default: state_next = BS_FIRST;
      endcase
    end
  end

  // result selection for the current step
  always_comb begin
    out_next.kind             = head.main_kind;
    out_next.write_offset     = head.main_offset;
    out_next.pulse_tag        = head.main_pulse;
    out_next.frame_seq        = head.main_frame;
    out_next.debug_info       = head.main_debug;
    out_next.module_tag       = module_number;
    out_next.packets_received = head.main_count;
    out_next.forward          = 1'b0;
    out_next.last             = !head.post_close;
    unique case (state)
      BS_FIRST: begin
        if (head.pre_close) begin
          out_next.kind             = KIND_DONE;
          out_next.write_offset     = '0;
          out_next.pulse_tag        = head.pre_pulse;
          out_next.frame_seq        = head.pre_frame;
          out_next.debug_info       = head.pre_debug;
          out_next.packets_received = head.pre_count;
          out_next.forward          = head.pre_forward;
          out_next.last             = 1'b0;
        end
      end
      BS_MAIN: begin
      end
      BS_POST: begin
        out_next.kind         = KIND_DONE;
        out_next.write_offset = '0;
        out_next.forward      = head.post_forward;
        out_next.last         = 1'b1;
      end
      default: begin
      end
    endcase
    pop = load && out_next.last;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_FIRST;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= out_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.kind             = out_reg.kind;
  assign result.write_offset     = out_reg.write_offset;
  assign result.pulse_tag        = out_reg.pulse_tag;
  assign result.frame_seq        = out_reg.frame_seq;
  assign result.debug_info       = out_reg.debug_info;
  assign result.module_tag       = out_reg.module_tag;
  assign result.packets_received = out_reg.packets_received;
  assign result.forward          = out_reg.forward;
  assign result.last             = out_reg.last;

`ifndef ASSERT_OFF
  a_mid_request_has_head: assert property (@(posedge clk) disable iff (rst)
      (state != BS_FIRST) |-> !empty)
    else $error("sequencer left mid-request with no request queued");
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
      (result.valid && result.kind == KIND_ERROR) |->
      (result.write_offset == '0 && !result.forward))
    else $error("error result carries offset or forward flag");
  a_place_then_done: assert property (@(posedge clk) disable iff (rst)
      (result.valid && result.ready && result.kind == KIND_PLACE && !result.last) |=>
      (result.valid && result.kind == KIND_DONE))
    else $error("final-packet close did not follow its placement");
`endif

endmodule
`default_nettype wire

// File: hdl/detector_packet_frame_assembler_top.sv
// top level of the detector packet frame assembler
// The assembler takes one packet header per cycle on the header channel and
// returns one to three results per header on the result channel: a close of
// the open frame when the bunch id changes, then a payload placement or a
// packet index error, then a close when the packet is the last of its frame.
// The front end accepts a header every cycle while its two-request queue has
// room; the back end sends one result per cycle from its output register
// while the result channel is ready, and a header's first result is presented
// after passing the request queue and the output register. The user writes
// configuration through cfg_write/cfg_index/cfg_data while idle, unchecked by the block.
`default_nettype none
module detector_packet_frame_assembler_top
  import dpfa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  dpfa_header_if.sink                 header,
  dpfa_result_if.source               result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data
);

  logic [31:0]  module_number;
  logic [63:0]  forward_min_pulse;
  logic         push, pop, empty, full;
  queue_entry_t push_entry, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      module_number     <= '0;
      forward_min_pulse <= FORWARD_MIN_PULSE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODULE_NUMBER:     module_number     <= cfg_data[31:0];
        REG_FORWARD_MIN_PULSE: forward_min_pulse <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dpfa_front u_front (
    .clk               (clk),
    .rst               (rst),
    .header            (header),
    .forward_min_pulse (forward_min_pulse),
    .full              (full),
    .push              (push),
    .entry             (push_entry)
  );

  dpfa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  dpfa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .module_number (module_number),
    .pop           (pop),
    .result        (result)
  );

endmodule
`default_nettype wire
